// ===== design/llst_pkg.sv =====
// ----------------------------------------------------------------------------
// llst_pkg: shared types and constants of the linked list engine
// Sizes, operation and status codes, and the command word that the
// sequencer broadcasts to the row of storage cells.
// ----------------------------------------------------------------------------
package llst_pkg;

    // Sizes
    localparam int LIST_DEPTH = 16;
    localparam int DATA_BITS  = 32;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    // Operation codes on func
    localparam logic [1:0] FUNC_INS_HEAD = 2'd0;
    localparam logic [1:0] FUNC_INS_TAIL = 2'd1;
    localparam logic [1:0] FUNC_DELETE   = 2'd2;
    localparam logic [1:0] FUNC_DISPLAY  = 2'd3;

    // Status codes on status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // What every cell does in a cycle
    typedef enum logic [2:0] {
        OP_HOLD,    // keep the stored value
        OP_PUSH,    // shift towards the tail, cell 0 takes the new value
        OP_LOAD,    // the cell at pos takes the new value
        OP_ROT,     // rotate towards cell 0 over cells 0..pos
        OP_DROP     // shift towards cell 0 over cells 0..pos, cell 0 is lost
    } cell_op_t;

    typedef struct packed {
        cell_op_t                      op;
        logic [CNT_W-1:0]              pos;
        logic signed [DATA_BITS-1:0]   value;
    } cell_cmd_t;

endpackage

// ===== design/llst_cell.sv =====
// ----------------------------------------------------------------------------
// llst_cell: one storage cell of the list row
// Holds one list element; cell k holds the k-th element from the head.
// Takes its neighbour's value on shifts and rotations.
// ----------------------------------------------------------------------------
module llst_cell
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [llst_pkg::CNT_W-1:0]           idx,
    input  llst_pkg::cell_cmd_t                  cmd,
    input  logic signed [llst_pkg::DATA_BITS-1:0] left_value,
    input  logic signed [llst_pkg::DATA_BITS-1:0] right_value,
    input  logic signed [llst_pkg::DATA_BITS-1:0] head_value,
    output logic signed [llst_pkg::DATA_BITS-1:0] cell_value
);

    logic signed [llst_pkg::DATA_BITS-1:0] value_reg;
    logic signed [llst_pkg::DATA_BITS-1:0] value_next;

    // Next value from the broadcast command
    always_comb
    begin
        value_next = value_reg;
        case (cmd.op)
            llst_pkg::OP_HOLD:
            begin
                value_next = value_reg;
            end
            llst_pkg::OP_PUSH:
            begin
                value_next = (idx == '0) ? cmd.value : left_value;
            end
            llst_pkg::OP_LOAD:
            begin
                if (idx == cmd.pos)
                begin
                    value_next = cmd.value;
                end
            end
            llst_pkg::OP_ROT:
            begin
                if (idx < cmd.pos)
                begin
                    value_next = right_value;
                end
                else if (idx == cmd.pos)
                begin
                    value_next = head_value;
                end
            end
            llst_pkg::OP_DROP:
            begin
                if (idx < cmd.pos)
                begin
                    value_next = right_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    // Element storage; contents beyond the fill count are don't care
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign cell_value = value_reg;

endmodule

// ===== design/llst_ctrl.sv =====
// ----------------------------------------------------------------------------
// llst_ctrl: operation sequencer of the linked list engine
// Keeps the fill count, decodes each command transfer into cell commands,
// walks the row for delete and display, and drives the result strobe.
// ----------------------------------------------------------------------------
module llst_ctrl
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           func,
    input  logic signed [llst_pkg::DATA_BITS-1:0] value,
    input  logic signed [llst_pkg::DATA_BITS-1:0] head_value,
    output llst_pkg::cell_cmd_t                  cmd,
    output logic                                 strobe,
    output logic [1:0]                           status,
    output logic signed [llst_pkg::DATA_BITS-1:0] data,
    output logic                                 last
);

    typedef enum logic {
        S_IDLE,
        S_WALK
    } state_t;

    localparam logic [llst_pkg::CNT_W-1:0] FULL_COUNT = llst_pkg::CNT_W'(llst_pkg::LIST_DEPTH);
    localparam logic [llst_pkg::CNT_W-1:0] ONE        = llst_pkg::CNT_W'(1);

    state_t                                 state_reg, state_next;
    logic [llst_pkg::CNT_W-1:0]             count_reg, count_next;
    logic [llst_pkg::CNT_W-1:0]             step_reg, step_next;
    logic [llst_pkg::CNT_W-1:0]             total_reg, total_next;
    logic [1:0]                             func_reg, func_next;
    logic signed [llst_pkg::DATA_BITS-1:0]  key_reg, key_next;
    logic                                   found_reg, found_next;
    logic                                   strobe_reg, strobe_next;
    logic [1:0]                             status_reg, status_next;
    logic signed [llst_pkg::DATA_BITS-1:0]  data_reg, data_next;
    logic                                   last_reg, last_next;
    logic                                   walk_end;

    assign walk_end = (step_reg == total_reg - ONE);

    // Sequencing and cell command decode
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        step_next   = step_reg;
        total_next  = total_reg;
        func_next   = func_reg;
        key_next    = key_reg;
        found_next  = found_reg;
        strobe_next = 1'b0;
        status_next = llst_pkg::ST_OK;
        data_next   = '0;
        last_next   = 1'b0;
        cmd.op      = llst_pkg::OP_HOLD;
        cmd.pos     = count_reg;
        cmd.value   = value;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (func)
                        llst_pkg::FUNC_INS_HEAD, llst_pkg::FUNC_INS_TAIL:
                        begin
                            strobe_next = 1'b1;
                            last_next   = 1'b1;
                            if (count_reg == FULL_COUNT)
                            begin
                                status_next = llst_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.op     = (func == llst_pkg::FUNC_INS_HEAD) ?
                                             llst_pkg::OP_PUSH : llst_pkg::OP_LOAD;
                                count_next = count_reg + ONE;
                            end
                        end
                        default:
                        begin
                            // delete and display walk the whole list
                            if (count_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                last_next   = 1'b1;
                                status_next = llst_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_WALK;
                                step_next  = '0;
                                total_next = count_reg;
                                func_next  = func;
                                key_next   = value;
                                found_next = 1'b0;
                            end
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                // head element leaves cell 0 each cycle and goes round to the back
                cmd.op    = llst_pkg::OP_ROT;
                cmd.pos   = count_reg - ONE;
                step_next = step_reg + ONE;
                if (func_reg == llst_pkg::FUNC_DISPLAY)
                begin
                    strobe_next = 1'b1;
                    data_next   = head_value;
                    last_next   = walk_end;
                end
                else
                begin
                    // first match is dropped instead of going round
                    if (!found_reg && (head_value == key_reg))
                    begin
                        cmd.op     = llst_pkg::OP_DROP;
                        count_next = count_reg - ONE;
                        found_next = 1'b1;
                    end
                    if (walk_end)
                    begin
                        strobe_next = 1'b1;
                        last_next   = 1'b1;
                        status_next = found_next ? llst_pkg::ST_OK : llst_pkg::ST_MISSING;
                    end
                end
                if (walk_end)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            step_reg   <= '0;
            total_reg  <= '0;
            func_reg   <= llst_pkg::FUNC_INS_HEAD;
            key_reg    <= '0;
            found_reg  <= 1'b0;
            strobe_reg <= 1'b0;
            status_reg <= llst_pkg::ST_OK;
            data_reg   <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            step_reg   <= step_next;
            total_reg  <= total_next;
            func_reg   <= func_next;
            key_reg    <= key_next;
            found_reg  <= found_next;
            strobe_reg <= strobe_next;
            status_reg <= status_next;
            data_reg   <= data_next;
            last_reg   <= last_next;
        end
    end

    assign busy   = (state_reg == S_WALK);
    assign strobe = strobe_reg;
    assign status = status_reg;
    assign data   = data_reg;
    assign last   = last_reg;

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("fill count beyond pool size");

    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (count_reg != '0))
        else $error("walk running over an empty list");

    a_found_delete: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg && (state_reg == S_WALK) |-> (func_reg == llst_pkg::FUNC_DELETE))
        else $error("match flag set outside a delete");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (count_reg != FULL_COUNT) &&
        ((func == llst_pkg::FUNC_INS_HEAD) || (func == llst_pkg::FUNC_INS_TAIL))
        |=> (count_reg == $past(count_reg) + ONE))
        else $error("insert did not grow the list");

    a_walk_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) && walk_end |=> strobe_reg && last_reg)
        else $error("walk ended without a final result");

endmodule

// ===== design/linked_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// linked_list_engine_unit: ordered list engine built as a row of cells
// Insert at head or tail, delete first match and display of a list of up
// to LIST_DEPTH values.
// ----------------------------------------------------------------------------
// Usage
//   Command channel: a command (func, value) is transferred at a rising edge
//   with start high and busy low.
//   Result channel: each result sits on status, data and last for one cycle
//   with strobe high; the receiver cannot stall it, so it must take every
//   result as it comes.
//   Results and rate: inserts, and delete or display of an empty list, give
//   their single result in the cycle after the transfer and busy stays low,
//   so a command can follow every cycle. Delete and display of n entries
//   rotate the cell row once per cycle with busy high during the walk;
//   display gives one result per entry, delete a single result at the end
//   of the walk, and the next command waits until busy is low again.
//   Reset: the list is empty and the engine idle; cell contents are
//   meaningless until written.
// ----------------------------------------------------------------------------
module linked_list_engine_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           func,
    input  logic signed [llst_pkg::DATA_BITS-1:0] value,
    output logic                                 strobe,
    output logic [1:0]                           status,
    output logic signed [llst_pkg::DATA_BITS-1:0] data,
    output logic                                 last
);

    llst_pkg::cell_cmd_t                   cmd;
    logic signed [llst_pkg::DATA_BITS-1:0] cell_value [llst_pkg::LIST_DEPTH];

    // Sequencer
    llst_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .value      (value),
        .head_value (cell_value[0]),
        .cmd        (cmd),
        .strobe     (strobe),
        .status     (status),
        .data       (data),
        .last       (last)
    );

    // Row of cells, cell 0 holds the head
    for (genvar i = 0; i < llst_pkg::LIST_DEPTH; i++)
    begin : g_cell
        logic signed [llst_pkg::DATA_BITS-1:0] left_value;
        logic signed [llst_pkg::DATA_BITS-1:0] right_value;

        if (i == 0)
        begin : g_first
            assign left_value = cmd.value;
        end
        else
        begin : g_inner_left
            assign left_value = cell_value[i-1];
        end

        if (i == llst_pkg::LIST_DEPTH - 1)
        begin : g_final
            assign right_value = cell_value[i];
        end
        else
        begin : g_inner_right
            assign right_value = cell_value[i+1];
        end

        llst_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .idx         (llst_pkg::CNT_W'(i)),
            .cmd         (cmd),
            .left_value  (left_value),
            .right_value (right_value),
            .head_value  (cell_value[0]),
            .cell_value  (cell_value[i])
        );
    end

endmodule

// ===== sim/list_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// list_result_checker: result checker for the linked list engine
// Watches the command and result channels, keeps its own ordered copy of the
// list, works out the results of every command transfer and compares each
// result transfer with the oldest result still owed.
// ----------------------------------------------------------------------------
module list_result_checker
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  busy,
    input  logic [1:0]                            func,
    input  logic signed [llst_pkg::DATA_BITS-1:0] value,
    input  logic                                  strobe,
    input  logic [1:0]                            status,
    input  logic signed [llst_pkg::DATA_BITS-1:0] data,
    input  logic                                  last,
    output int                                    error_count,
    output int                                    outstanding,
    output int                                    results_checked
);

    typedef struct packed {
        logic [1:0]                            status;
        logic signed [llst_pkg::DATA_BITS-1:0] data;
        logic                                  last;
    } list_result_t;

    // list contents, head first, and the results still owed by the engine
    logic signed [llst_pkg::DATA_BITS-1:0] stored_values[$];
    list_result_t                          owed_results[$];
    list_result_t                          oldest;

    // Apply one command to the list copy and queue what it must produce
    task automatic apply_list_command(input logic [1:0] op,
                                      input logic signed [llst_pkg::DATA_BITS-1:0] v);
        int hit;
        int n;
        hit = -1;
        n   = stored_values.size();
        case (op)
            llst_pkg::FUNC_INS_HEAD, llst_pkg::FUNC_INS_TAIL:
            begin
                // a full pool refuses the insert and leaves the list alone
                if (n >= llst_pkg::LIST_DEPTH)
                    owed_results.push_back('{llst_pkg::ST_FULL, '0, 1'b1});
                else
                begin
                    if (op == llst_pkg::FUNC_INS_HEAD)
                        stored_values.push_front(v);
                    else
                        stored_values.push_back(v);
                    owed_results.push_back('{llst_pkg::ST_OK, '0, 1'b1});
                end
            end
            llst_pkg::FUNC_DELETE:
            begin
                if (n == 0)
                    owed_results.push_back('{llst_pkg::ST_EMPTY, '0, 1'b1});
                else
                begin
                    // first match only
                    foreach (stored_values[i])
                        if (hit < 0 && stored_values[i] == v)
                            hit = i;
                    if (hit < 0)
                        owed_results.push_back('{llst_pkg::ST_MISSING, '0, 1'b1});
                    else
                    begin
                        stored_values.delete(hit);
                        owed_results.push_back('{llst_pkg::ST_OK, '0, 1'b1});
                    end
                end
            end
            default:
            begin
                // display: one result per element, last on the tail
                if (n == 0)
                    owed_results.push_back('{llst_pkg::ST_EMPTY, '0, 1'b1});
                else
                    foreach (stored_values[i])
                        owed_results.push_back('{llst_pkg::ST_OK, stored_values[i],
                                                 i == n - 1});
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_values.delete();
            owed_results.delete();
            error_count     = 0;
            results_checked = 0;
        end
        else
        begin
            // results first, so a command taken at this edge cannot cover a stray result
            if (strobe)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0t: unexpected result status=%0d data=%0d last=%0b",
                             $time, status, data, last);
                    error_count++;
                end
                else
                begin
                    oldest = owed_results.pop_front();
                    results_checked++;
                    if (status !== oldest.status || data !== oldest.data
                        || last !== oldest.last)
                    begin
                        $display("%0t: result mismatch: expected status=%0d data=%0d last=%0b",
                                 $time, oldest.status, oldest.data, oldest.last);
                        $display("%0t:                  actual   status=%0d data=%0d last=%0b",
                                 $time, status, data, last);
                        error_count++;
                    end
                end
            end

            // command transfer
            if (start && !busy)
                apply_list_command(func, value);
        end
        outstanding = owed_results.size();
    end

endmodule

// ===== sim/linked_list_engine_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linked_list_engine_unit_test: testbench for the linked list engine
// Drives a directed run through the corner cases (empty list, missing value,
// tail delete, full pool, extreme values) and then random command mixes that
// swing between filling and draining the list, with several amounts of sender
// idling. Results are checked by list_result_checker.
// ----------------------------------------------------------------------------
module linked_list_engine_unit_test;

    localparam int DATA_BITS        = llst_pkg::DATA_BITS;
    localparam int LIST_DEPTH       = llst_pkg::LIST_DEPTH;
    localparam int CLK_HIGH         = 6;
    localparam int CLK_LOW          = 6;
    localparam int RESET_CYCLES     = 7;
    localparam int RANDOM_PER_PHASE = 120;
    localparam int SWING_ITEMS      = 30;
    localparam int RECENT_KEEP      = 16;
    localparam int DRAIN_LIMIT      = 400;
    localparam int SETTLE_CYCLES    = LIST_DEPTH + 4;
    localparam int CYCLE_LIMIT      = 200000;

    localparam logic signed [DATA_BITS-1:0] DATA_MAX     = {1'b0, {(DATA_BITS-1){1'b1}}};
    localparam logic signed [DATA_BITS-1:0] DATA_MIN     = {1'b1, {(DATA_BITS-1){1'b0}}};
    localparam logic signed [DATA_BITS-1:0] DATA_ONES    = '1;
    localparam logic signed [DATA_BITS-1:0] FILL_PATTERN = 32'sh5A5A_A5A5;

    logic                        clk   = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic [1:0]                  func  = llst_pkg::FUNC_INS_HEAD;
    logic signed [DATA_BITS-1:0] value = '0;
    logic                        busy;
    logic                        strobe;
    logic [1:0]                  status;
    logic signed [DATA_BITS-1:0] data;
    logic                        last;

    logic                        cmd_taken = 1'b0;
    logic                        filling   = 1'b1;
    int                          idle_pct  = 0;
    int                          cycles    = 0;
    int                          drain;
    int                          op_count[4] = '{default: 0};
    int                          error_count;
    int                          outstanding;
    int                          results_checked;
    logic signed [DATA_BITS-1:0] recent_values[$];

    // Clock
    always
    begin
        #CLK_LOW  clk = 1'b1;
        #CLK_HIGH clk = 1'b0;
    end

    linked_list_engine_unit u_top
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .func   (func),
        .value  (value),
        .strobe (strobe),
        .status (status),
        .data   (data),
        .last   (last)
    );

    list_result_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .func            (func),
        .value           (value),
        .strobe          (strobe),
        .status          (status),
        .data            (data),
        .last            (last),
        .error_count     (error_count),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    // Command transfer seen at the edge, read back at the next falling edge
    always @(posedge clk)
        cmd_taken <= start && !busy;

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: run stopped after %0d cycles, %0d results outstanding",
                     $time, cycles, outstanding);
            $display("[linked_list_engine_unit] ERROR");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_cmd(input logic [1:0] f, input logic signed [DATA_BITS-1:0] v);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        func  <= f;
        value <= v;
        do @(negedge clk); while (!cmd_taken);
        op_count[f]++;
        if (f == llst_pkg::FUNC_INS_HEAD || f == llst_pkg::FUNC_INS_TAIL)
        begin
            recent_values.push_back(v);
            if (recent_values.size() > RECENT_KEEP)
                void'(recent_values.pop_front());
        end
    endtask

    // Mostly small values so that deletes find duplicates, plus extremes and noise
    function automatic logic signed [DATA_BITS-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return DATA_BITS'($urandom_range(7));
        if (r < 70)
        begin
            case ($urandom_range(3))
                0:       return DATA_MAX;
                1:       return DATA_MIN;
                2:       return DATA_ONES;
                default: return '0;
            endcase
        end
        return DATA_BITS'($urandom);
    endfunction

    // Random commands, swinging between filling and draining the list
    task automatic run_random(input int n);
        int unsigned                 r;
        logic signed [DATA_BITS-1:0] target;
        for (int k = 0; k < n; k++)
        begin
            if (k % SWING_ITEMS == 0)
                filling = !filling;
            r = $urandom_range(99);
            if (r < (filling ? 55 : 20))
                send_cmd(r[0] ? llst_pkg::FUNC_INS_TAIL : llst_pkg::FUNC_INS_HEAD,
                         pick_value());
            else if (r < (filling ? 82 : 85))
            begin
                // while draining, mostly aim at values that were stored
                target = pick_value();
                if (!filling && recent_values.size() != 0 && $urandom_range(9) < 7)
                    target = recent_values[$urandom_range(recent_values.size() - 1)];
                send_cmd(llst_pkg::FUNC_DELETE, target);
            end
            else
                send_cmd(llst_pkg::FUNC_DISPLAY, pick_value());
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty list
        send_cmd(llst_pkg::FUNC_DISPLAY, '0);
        send_cmd(llst_pkg::FUNC_DELETE, DATA_MAX);
        // extremes at both ends: -1, max, min, 0
        send_cmd(llst_pkg::FUNC_INS_HEAD, DATA_MAX);
        send_cmd(llst_pkg::FUNC_INS_TAIL, DATA_MIN);
        send_cmd(llst_pkg::FUNC_INS_HEAD, DATA_ONES);
        send_cmd(llst_pkg::FUNC_INS_TAIL, '0);
        // missing value, tail delete, then an append checks the moved tail
        send_cmd(llst_pkg::FUNC_DELETE, 1);
        send_cmd(llst_pkg::FUNC_DELETE, '0);
        send_cmd(llst_pkg::FUNC_INS_TAIL, 32'sh5555_5555);
        // head delete
        send_cmd(llst_pkg::FUNC_DELETE, DATA_ONES);
        // three entries left; fill the pool with duplicates at both ends
        for (int i = 0; i < LIST_DEPTH - 3; i++)
            send_cmd(i[0] ? llst_pkg::FUNC_INS_TAIL : llst_pkg::FUNC_INS_HEAD,
                     (i % 3 == 0) ? FILL_PATTERN : DATA_BITS'(i % 4));
        send_cmd(llst_pkg::FUNC_INS_HEAD, 32'shAAAA_AAAA);
        send_cmd(llst_pkg::FUNC_DISPLAY, '0);

        // random part under three amounts of sender idling
        idle_pct = 0;
        run_random(RANDOM_PER_PHASE);
        idle_pct = 82;
        run_random(RANDOM_PER_PHASE);
        idle_pct = 31;
        run_random(RANDOM_PER_PHASE);
        start <= 1'b0;

        // let the last results come out, then watch for strays
        for (drain = 0; drain < DRAIN_LIMIT && outstanding != 0; drain++)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (outstanding != 0)
            $display("%0t: %0d expected results never arrived", $time, outstanding);
        $display("commands: %0d insert at head, %0d insert at tail, %0d delete, %0d display",
                 op_count[llst_pkg::FUNC_INS_HEAD], op_count[llst_pkg::FUNC_INS_TAIL],
                 op_count[llst_pkg::FUNC_DELETE], op_count[llst_pkg::FUNC_DISPLAY]);
        $display("%0d results checked with sender idling of 0, 82 and 31 per cent, %0d mismatches",
                 results_checked, error_count);
        if (error_count == 0 && outstanding == 0)
            $display("[linked_list_engine_unit] OK");
        else
            $display("[linked_list_engine_unit] ERROR");
        $finish;
    end

endmodule
